[rtl/region_adjacency_counter_assert.svh]
// Assertion macros for the region adjacency counter RTL.
`ifndef REGION_ADJACENCY_COUNTER_ASSERT_SVH
`define REGION_ADJACENCY_COUNTER_ASSERT_SVH

// Check that cond holds in the same cycle as trig.
`define RAC_ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle check");

// Check that cond holds in the cycle after trig.
`define RAC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle check");

`endif

[rtl/rac_pkg.sv]
// Shared types, widths and constants of the region adjacency counter.
package rac_pkg;

  localparam int LBL_W  = 12;
  localparam int CNT_W  = 26;
  localparam int DIM_W  = 13;
  localparam int ROW_W  = 12;
  localparam int TOT_W  = 11;
  localparam int MAX_ROWS = 4096;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int MAX_LABELS_DEF = 4096;
  localparam int MAX_EDGES_DEF  = 1024;
  localparam int MAX_WIDTH_DEF  = 4096;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    ACT_PIXEL   = 2'd0,
    ACT_RD_EDGE = 2'd1,
    ACT_RD_LEN  = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2,
    REG_NONE   = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [LBL_W-1:0] pixel_label;
    logic [LBL_W-1:0] query_index;
  } pix_item_t;

  typedef struct packed {
    logic             entry_found;
    logic [LBL_W-1:0] label_low;
    logic [LBL_W-1:0] label_high;
    logic [CNT_W-1:0] pair_count;
    logic [CNT_W-1:0] region_length;
    logic [TOT_W-1:0] edge_total;
    logic             table_overflow;
  } res_item_t;

  typedef struct packed {
    logic [1:0]       reg_index;
    logic [DIM_W-1:0] wdata;
  } cfg_item_t;

endpackage

[rtl/rac_if.sv]
// Valid/ready channel interfaces of the region adjacency counter.
interface rac_pix_if;
  logic                valid;
  logic                ready;
  rac_pkg::pix_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rac_res_if;
  logic                valid;
  logic                ready;
  rac_pkg::res_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rac_cfg_if;
  logic                valid;
  logic                ready;
  rac_pkg::cfg_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/region_adjacency_counter.sv]
// Region adjacency counter: streams a label image and counts region adjacencies.
//
// Channels: pix_i carries one transaction per pixel, edge read, length read or
// clear (action field). res_o returns one transaction for each edge read or
// length read; pixels and clears return nothing. cfg_i writes image width,
// height and adjacency mode; it is ready only while the block is idle, and a
// pending cfg_i transaction holds pix_i off for that cycle.
// Sequencing: a pixel passes through ST_PX_LOAD and then, for each of its two
// pair slots, through ST_PAIR alone when no pair is counted, else through
// ST_PAIR, a linear key search through the edge key memory (one read per
// cycle and one per occupied edge slot scanned, none while the table is empty)
// and ST_LEN_A, ST_LEN_AW and ST_LEN_BW. A read loads the result register from
// ST_Q_EDGE or ST_Q_LEN. A clear runs a zeroing pass over max(MAX_LABELS,
// MAX_WIDTH) entries of the line buffers and the length memory, one entry per
// cycle; the same pass runs after reset, and pix_i is not ready during it.
// Stalls: the result register holds a finished result while res_o is stalled;
// pixels and clears are still taken. A further read waits in its final state
// until the result register frees up.
// Reset: registers return to their defaults, the edge table empties, the
// overflow flag drops and the zeroing pass starts.
module region_adjacency_counter #(
  parameter int MAX_LABELS = rac_pkg::MAX_LABELS_DEF,
  parameter int MAX_EDGES  = rac_pkg::MAX_EDGES_DEF,
  parameter int MAX_WIDTH  = rac_pkg::MAX_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rac_pix_if.sink   pix_i,
  rac_res_if.source res_o,
  rac_cfg_if.sink   cfg_i
);

  `include "region_adjacency_counter_assert.svh"

  localparam int LBL_W = rac_pkg::LBL_W;
  localparam int CNT_W = rac_pkg::CNT_W;
  localparam int DIM_W = rac_pkg::DIM_W;
  localparam int TOT_W = rac_pkg::TOT_W;
  localparam int LAW   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EUW   = $clog2(MAX_EDGES + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CLR_N = (MAX_LABELS > MAX_WIDTH) ? MAX_LABELS : MAX_WIDTH;
  localparam int CLW   = $clog2(CLR_N);
  localparam int KEY_W = 2 * LBL_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PX_LOAD, ST_PAIR, ST_SRCH,
    ST_LEN_A, ST_LEN_AW, ST_LEN_BW, ST_Q_EDGE, ST_Q_LEN
  } state_e;

  // Memories
  logic [LBL_W-1:0] row_prev_mem  [MAX_WIDTH];
  logic [LBL_W-1:0] row_prev2_mem [MAX_WIDTH];
  logic [KEY_W-1:0] key_mem       [MAX_EDGES];
  logic [CNT_W-1:0] cnt_mem       [MAX_EDGES];
  logic [CNT_W-1:0] len_mem       [MAX_LABELS];

  logic [LBL_W-1:0] up_rd_q, up2_rd_q;
  logic [KEY_W-1:0] key_rd_q;
  logic [CNT_W-1:0] cnt_rd_q, len_rd_q;

  // Control state
  state_e              state_q;
  logic [CLW-1:0]      clr_q;
  logic [DIM_W-1:0]    img_w_q, img_h_q;
  logic                mode_q;
  logic [XW-1:0]       col_q;
  logic [rac_pkg::ROW_W-1:0] row_q;
  logic [LBL_W-1:0]    left1_q, left2_q;
  logic [EUW-1:0]      edges_used_q;
  logic                ovf_q;
  logic [LBL_W-1:0]    pix_q, q_q;
  logic                hit_q;
  logic [LBL_W-1:0]    pair_a_q [2];
  logic [LBL_W-1:0]    pair_b_q [2];
  logic [1:0]          pair_v_q;
  logic                sel_q;
  logic [EAW-1:0]      idx_q;
  logic                out_v_q;
  rac_pkg::res_item_t  out_q;
  rac_pkg::res_item_t  out_d;

  // Geometry
  logic [WW-1:0]       w_eff;
  logic [DIM_W-1:0]    h_eff;
  logic [XW-1:0]       x_cur;

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(img_w_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_w_q);
    end
    if (img_h_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(img_h_q) > rac_pkg::MAX_ROWS) begin
      h_eff = DIM_W'(rac_pkg::MAX_ROWS);
    end else begin
      h_eff = img_h_q;
    end
    x_cur = (32'(col_q) >= 32'(w_eff)) ? XW'(w_eff - WW'(1)) : col_q;
  end

  // Current pair and its key
  logic [LBL_W-1:0] cur_a, cur_b, cur_lo, cur_hi;
  logic [KEY_W-1:0] cur_key;
  logic             cur_v, key_match, scan_last, table_free, insert_go;

  assign cur_a      = pair_a_q[sel_q];
  assign cur_b      = pair_b_q[sel_q];
  assign cur_v      = pair_v_q[sel_q];
  assign cur_lo     = (cur_a < cur_b) ? cur_a : cur_b;
  assign cur_hi     = (cur_a < cur_b) ? cur_b : cur_a;
  assign cur_key    = {cur_lo, cur_hi};
  assign key_match  = (key_rd_q == cur_key);
  assign scan_last  = (32'(idx_q) + 32'd1 >= 32'(edges_used_q));
  assign table_free = (32'(edges_used_q) < MAX_EDGES);
  assign insert_go  = ((state_q == ST_PAIR) && cur_v && (edges_used_q == '0)) ||
                      ((state_q == ST_SRCH) && !key_match && scan_last);

  // Handshakes
  logic pix_acc, cfg_acc, res_free, out_load;
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign pix_i.ready = (state_q == ST_IDLE) && !cfg_i.valid;
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign res_free    = !out_v_q || res_o.ready;
  assign out_load    = ((state_q == ST_Q_EDGE) || (state_q == ST_Q_LEN)) && res_free;
  assign res_o.valid   = out_v_q;
  assign res_o.payload = out_q;

  // Result word for the read in progress
  always_comb begin
    out_d                = '0;
    out_d.edge_total     = TOT_W'(edges_used_q);
    out_d.table_overflow = ovf_q;
    if (state_q == ST_Q_EDGE) begin
      out_d.entry_found = hit_q;
      out_d.label_low   = hit_q ? key_rd_q[KEY_W-1:LBL_W] : '0;
      out_d.label_high  = hit_q ? key_rd_q[LBL_W-1:0] : '0;
      out_d.pair_count  = hit_q ? cnt_rd_q : '0;
    end else begin
      out_d.region_length = (32'(q_q) < MAX_LABELS) ? len_rd_q : '0;
    end
  end

  // Memory ports
  logic             row_we;
  logic [XW-1:0]    row_waddr;
  logic [LBL_W-1:0] row_wd, row2_wd;
  logic             edge_we_key, edge_we_cnt;
  logic [EAW-1:0]   edge_waddr, edge_raddr;
  logic [CNT_W-1:0] edge_cnt_wd;
  logic             len_we;
  logic [LAW-1:0]   len_waddr, len_raddr;
  logic [CNT_W-1:0] len_wd;

  always_comb begin
    row_we    = 1'b0;
    row_waddr = x_cur;
    row_wd    = pix_q;
    row2_wd   = up_rd_q;
    if (state_q == ST_CLEAR) begin
      row_we    = (32'(clr_q) < MAX_WIDTH);
      row_waddr = XW'(clr_q);
      row_wd    = '0;
      row2_wd   = '0;
    end else if (state_q == ST_PX_LOAD) begin
      row_we = 1'b1;
    end

    edge_we_key = insert_go && table_free;
    edge_we_cnt = edge_we_key || ((state_q == ST_SRCH) && key_match);
    edge_waddr  = edge_we_key ? EAW'(edges_used_q) : idx_q;
    edge_cnt_wd = edge_we_key ? CNT_W'(1) :
                  ((cnt_rd_q == rac_pkg::CNT_MAX) ? cnt_rd_q : cnt_rd_q + CNT_W'(1));

    unique case (state_q)
      ST_IDLE:   edge_raddr = EAW'(pix_i.payload.query_index);
      ST_SRCH:   edge_raddr = idx_q + EAW'(1);
      ST_Q_EDGE: edge_raddr = EAW'(q_q);
      default:   edge_raddr = '0;
    endcase

    unique case (state_q)
      ST_IDLE:   len_raddr = LAW'(pix_i.payload.query_index);
      ST_Q_LEN:  len_raddr = LAW'(q_q);
      ST_LEN_A:  len_raddr = LAW'(cur_a);
      ST_LEN_AW: len_raddr = LAW'(cur_b);
      default:   len_raddr = '0;
    endcase

    len_we    = 1'b0;
    len_waddr = LAW'(cur_a);
    len_wd    = (len_rd_q == rac_pkg::CNT_MAX) ? len_rd_q : len_rd_q + CNT_W'(1);
    if (state_q == ST_CLEAR) begin
      len_we    = (32'(clr_q) < MAX_LABELS);
      len_waddr = LAW'(clr_q);
      len_wd    = '0;
    end else if (state_q == ST_LEN_AW) begin
      len_we = (32'(cur_a) < MAX_LABELS);
    end else if (state_q == ST_LEN_BW) begin
      len_we    = (32'(cur_b) < MAX_LABELS);
      len_waddr = LAW'(cur_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_prev_mem[row_waddr]  <= row_wd;
      row_prev2_mem[row_waddr] <= row2_wd;
    end
    up_rd_q  <= row_prev_mem[x_cur];
    up2_rd_q <= row_prev2_mem[x_cur];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we_key) begin
      key_mem[edge_waddr] <= cur_key;
    end
    if (edge_we_cnt) begin
      cnt_mem[edge_waddr] <= edge_cnt_wd;
    end
    key_rd_q <= key_mem[edge_raddr];
    cnt_rd_q <= cnt_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wd;
    end
    len_rd_q <= len_mem[len_raddr];
  end

  // Pair selection at pixel load (uses the left labels before the shift)
  logic [LBL_W-1:0] p0_a, p0_b, p1_a, p1_b;
  logic             p0_c, p1_c;

  always_comb begin
    if (!mode_q) begin
      p0_a = left1_q;  p0_b = pix_q;  p0_c = (x_cur != '0);
      p1_a = up_rd_q;  p1_b = pix_q;  p1_c = (row_q != '0);
    end else begin
      p0_a = up2_rd_q; p0_b = pix_q;  p0_c = (32'(row_q) >= 32'd2) && (up_rd_q == '0);
      p1_a = left2_q;  p1_b = pix_q;  p1_c = (32'(x_cur) >= 32'd2) && (left1_q == '0);
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      img_w_q      <= rac_pkg::WIDTH_RST;
      img_h_q      <= rac_pkg::HEIGHT_RST;
      mode_q       <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
      left1_q      <= '0;
      left2_q      <= '0;
      edges_used_q <= '0;
      ovf_q        <= 1'b0;
      pix_q        <= '0;
      q_q          <= '0;
      hit_q        <= 1'b0;
      pair_a_q     <= '{default: '0};
      pair_b_q     <= '{default: '0};
      pair_v_q     <= '0;
      sel_q        <= 1'b0;
      idx_q        <= '0;
      out_v_q      <= 1'b0;
      out_q        <= '0;
    end else begin
      // Load a finished read, or drop the result once it is taken
      if (out_load) begin
        out_v_q <= 1'b1;
        out_q   <= out_d;
      end else if (out_v_q && res_o.ready) begin
        out_v_q <= 1'b0;
      end

      if (edge_we_key) begin
        edges_used_q <= edges_used_q + EUW'(1);
      end
      if (insert_go && !table_free) begin
        ovf_q <= 1'b1;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CLW'(1);
          if (32'(clr_q) == CLR_N - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pix_acc) begin
            pix_q <= pix_i.payload.pixel_label;
            q_q   <= pix_i.payload.query_index;
            hit_q <= (32'(pix_i.payload.query_index) < 32'(edges_used_q)) &&
                     (32'(pix_i.payload.query_index) < MAX_EDGES);
            unique case (rac_pkg::action_e'(pix_i.payload.action))
              rac_pkg::ACT_PIXEL:   state_q <= ST_PX_LOAD;
              rac_pkg::ACT_RD_EDGE: state_q <= ST_Q_EDGE;
              rac_pkg::ACT_RD_LEN:  state_q <= ST_Q_LEN;
              rac_pkg::ACT_CLEAR: begin
                state_q      <= ST_CLEAR;
                clr_q        <= '0;
                col_q        <= '0;
                row_q        <= '0;
                left1_q      <= '0;
                left2_q      <= '0;
                edges_used_q <= '0;
                ovf_q        <= 1'b0;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_PX_LOAD: begin
          pair_a_q[0] <= p0_a;
          pair_b_q[0] <= p0_b;
          pair_a_q[1] <= p1_a;
          pair_b_q[1] <= p1_b;
          pair_v_q[0] <= p0_c && (p0_a != '0) && (p0_b != '0) && (p0_a != p0_b);
          pair_v_q[1] <= p1_c && (p1_a != '0) && (p1_b != '0) && (p1_a != p1_b);
          sel_q       <= 1'b0;
          left2_q     <= left1_q;
          left1_q     <= pix_q;
          if (32'(x_cur) + 32'd1 >= 32'(w_eff)) begin
            col_q <= '0;
            row_q <= (32'(row_q) + 32'd1 >= 32'(h_eff)) ? '0 : row_q + 1'b1;
          end else begin
            col_q <= x_cur + XW'(1);
          end
          state_q <= ST_PAIR;
        end
        ST_PAIR: begin
          idx_q <= '0;
          if (!cur_v) begin
            // skip an empty pair slot
            if (sel_q) begin
              state_q <= ST_IDLE;
            end else begin
              sel_q <= 1'b1;
            end
          end else if (edges_used_q == '0) begin
            state_q <= ST_LEN_A;
          end else begin
            state_q <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (key_match || scan_last) begin
            state_q <= ST_LEN_A;
          end else begin
            idx_q <= idx_q + EAW'(1);
          end
        end
        ST_LEN_A:  state_q <= ST_LEN_AW;
        ST_LEN_AW: state_q <= ST_LEN_BW;
        ST_LEN_BW: begin
          if (sel_q) begin
            state_q <= ST_IDLE;
          end else begin
            sel_q   <= 1'b1;
            state_q <= ST_PAIR;
          end
        end
        ST_Q_EDGE, ST_Q_LEN: begin
          if (res_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // Any register write restarts the frame position
      if (cfg_acc) begin
        unique case (rac_pkg::reg_index_e'(cfg_i.payload.reg_index))
          rac_pkg::REG_WIDTH:  img_w_q <= cfg_i.payload.wdata;
          rac_pkg::REG_HEIGHT: img_h_q <= cfg_i.payload.wdata;
          rac_pkg::REG_MODE:   mode_q  <= cfg_i.payload.wdata[0];
          default: ;
        endcase
        if (cfg_i.payload.reg_index != rac_pkg::REG_NONE) begin
          col_q   <= '0;
          row_q   <= '0;
          left1_q <= '0;
          left2_q <= '0;
        end
      end
    end
  end

  // Assertions
  `RAC_ASSERT_SAME(a_edges_bound, clk_i, rst_ni, 1'b1, 32'(edges_used_q) <= MAX_EDGES)
  `RAC_ASSERT_NEXT(a_ovf_sticky, clk_i, rst_ni,
                   ovf_q && !(pix_acc && pix_i.payload.action == rac_pkg::ACT_CLEAR),
                   ovf_q)
  `RAC_ASSERT_NEXT(a_edges_step, clk_i, rst_ni, 1'b1,
                   edges_used_q == $past(edges_used_q) ||
                   edges_used_q == $past(edges_used_q) + EUW'(1) || edges_used_q == '0)
  `RAC_ASSERT_NEXT(a_result_held, clk_i, rst_ni,
                   out_v_q && !res_o.ready,
                   out_v_q && $stable(out_q))

endmodule
